FILE: rtl/cdoc_pkg.sv
// ============================================================================
// cdoc_pkg
// Shared types, month tables and constants for the calendar date converter.
// ============================================================================
`timescale 1ns / 1ps

package cdoc_pkg;

   localparam int YEAR_BITS_DEFAULT = 16;

   localparam logic CMD_TO_ORDINAL = 1'b0;
   localparam logic CMD_TO_DATE    = 1'b1;

   localparam int MONTHS = 12;

   localparam logic [4:0] MONTH_LEN [2][MONTHS] = '{
      '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31},
      '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31}
   };

   // Days that precede the first day of each month.
   localparam logic [8:0] CUM_DAYS [2][MONTHS] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
   };

   localparam logic [8:0] YEAR_LEN [2] = '{9'd365, 9'd366};

   typedef struct packed {
      logic       error;
      logic [8:0] ordinal;
      logic [3:0] month;
      logic [4:0] day;
   } result_type;

   // Multiplicative inverse of an odd number modulo 2^32 by Newton iteration.
   function automatic logic [31:0] inv_mod32(input logic [31:0] d);
      logic [31:0] x;
      x = d;
      for (int i = 0; i < 5; i++) begin
         x = 32'(x * (32'd2 - 32'(d * x)));
      end
      return x;
   endfunction

endpackage

FILE: rtl/cdoc_date_conv.sv
// ============================================================================
// cdoc_date_conv
// Month/day to ordinal and ordinal to month/day for one fixed year length.
// ============================================================================
`timescale 1ns / 1ps

module cdoc_date_conv (
   input  logic                  leap,
   input  logic                  cmd,
   input  logic [3:0]            month_in,
   input  logic [5:0]            day_in,
   input  logic [8:0]            ordinal_in,
   output cdoc_pkg::result_type  res
);
   import cdoc_pkg::*;

   logic       month_ok;
   logic [3:0] midx;
   logic       day_ok;
   logic [8:0] ord_sum;
   logic       ord_ok;
   logic [3:0] sel;
   logic [8:0] rem;

   always_comb begin
      month_ok = (month_in >= 4'd1) && (month_in <= 4'd12);
      midx     = month_ok ? 4'(month_in - 4'd1) : 4'd0;
      day_ok   = (day_in != 6'd0) && (day_in <= {1'b0, MONTH_LEN[leap][midx]});
      ord_sum  = CUM_DAYS[leap][midx] + {3'b000, day_in};
      ord_ok   = (ordinal_in != 9'd0) && (ordinal_in <= YEAR_LEN[leap]);

      sel = 4'd0;
      for (int k = 1; k < MONTHS; k++) begin
         if (ordinal_in > CUM_DAYS[leap][4'(k)]) begin
            sel = 4'(k);
         end
      end
      rem = ordinal_in - CUM_DAYS[leap][sel];

      res = '0;
      unique case (cmd)
         CMD_TO_ORDINAL: begin
            if (month_ok && day_ok) begin
               res.ordinal = ord_sum;
            end else begin
               res.error = 1'b1;
            end
         end
         CMD_TO_DATE: begin
            if (ord_ok) begin
               res.month = 4'(sel + 4'd1);
               res.day   = rem[4:0];
            end else begin
               res.error = 1'b1;
            end
         end
         default: res.error = 1'b1;
      endcase
   end

endmodule

FILE: rtl/calendar_date_ordinal_converter_core.sv
// ============================================================================
// calendar_date_ordinal_converter_core
// Gregorian day-of-year converter with a three-stage pipeline. It accepts one
// transaction per cycle when the output is not stalled; the pipeline depth
// is set by the leap-year path, which takes the year magnitude in the first
// stage, tests divisibility by 25 with a modular-inverse multiply in the
// second, and selects the leap or common result in the third. Command 0 maps
// month and day to the day of the year, command 1 maps the day of the year
// to month and day, and invalid input returns the error flag with all fields
// zero.
// ============================================================================
`timescale 1ns / 1ps

module calendar_date_ordinal_converter_core #(
   parameter int YEAR_BITS = cdoc_pkg::YEAR_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // year, month_in[3:0], day_in[5:0], ordinal_in[8:0], zero padding
   input  logic [((YEAR_BITS + 26) / 8) * 8 - 1:0] req_tdata,
   // cmd
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // ordinal_out[8:0], month_out[3:0], day_out[4:0], zero padding
   output logic [23:0] rsp_tdata,
   // error
   output logic rsp_tuser
);
   import cdoc_pkg::*;

   localparam logic [31:0] INV25_FULL = inv_mod32(32'd25);
   localparam logic [YEAR_BITS-1:0] DIV25_INV = INV25_FULL[YEAR_BITS-1:0];
   localparam logic [YEAR_BITS-1:0] DIV25_LIMIT =
      YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

   logic [YEAR_BITS-1:0] year;
   logic [3:0]           month_in;
   logic [5:0]           day_in;
   logic [8:0]           ordinal_in;

   assign year       = req_tdata[YEAR_BITS-1:0];
   assign month_in   = req_tdata[YEAR_BITS+3:YEAR_BITS];
   assign day_in     = req_tdata[YEAR_BITS+9:YEAR_BITS+4];
   assign ordinal_in = req_tdata[YEAR_BITS+18:YEAR_BITS+10];

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   logic [YEAR_BITS-1:0] mag_ff, mag_in;
   logic [YEAR_BITS-1:0] prod_ff, prod_in;
   logic [3:0]           low_ff;
   result_type           conv_res [2];
   result_type           res_s1_ff [2];
   result_type           res_s2_ff [2];
   result_type           out_ff, out_in;
   logic                 div25;
   logic                 leap;

   cdoc_date_conv u_conv_common (
      .leap       (1'b0),
      .cmd        (req_tuser),
      .month_in   (month_in),
      .day_in     (day_in),
      .ordinal_in (ordinal_in),
      .res        (conv_res[0])
   );

   cdoc_date_conv u_conv_leap (
      .leap       (1'b1),
      .cmd        (req_tuser),
      .month_in   (month_in),
      .day_in     (day_in),
      .ordinal_in (ordinal_in),
      .res        (conv_res[1])
   );

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_comb begin
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;

      mag_in  = year[YEAR_BITS-1] ? YEAR_BITS'(~year + 1'b1) : year;
      prod_in = YEAR_BITS'(mag_ff * DIV25_INV);

      // Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
      div25  = prod_ff <= DIV25_LIMIT;
      leap   = (low_ff[1:0] == 2'b00) && (!div25 || (low_ff[3:2] == 2'b00));
      out_in = leap ? res_s2_ff[1] : res_s2_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mag_ff       <= mag_in;
         res_s1_ff[0] <= conv_res[0];
         res_s1_ff[1] <= conv_res[1];
      end
      if (rdy2) begin
         prod_ff      <= prod_in;
         low_ff       <= mag_ff[3:0];
         res_s2_ff[0] <= res_s1_ff[0];
         res_s2_ff[1] <= res_s1_ff[1];
      end
      if (rdy3) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = out_ff.error;
   assign rsp_tdata  = {6'b000000, out_ff.day, out_ff.month, out_ff.ordinal};

`ifndef SYNTH
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("error result carries nonzero fields");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[8:0] != 9'd0) != (rsp_tdata[12:9] != 4'd0))
      else $error("result must carry either an ordinal or a date");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12:9] != 4'd0) |->
         (rsp_tdata[12:9] <= 4'd12) && (rsp_tdata[17:13] != 5'd0))
      else $error("month or day out of range");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalls with an empty output stage");
`endif

endmodule
